/* hdl/swvs_pkg.sv */
// Shared types and codes for the switch/value shadow table block.
package swvs_pkg;

    typedef enum logic [1:0] {
        CMD_SET_SWITCH = 2'd0,
        CMD_SET_VALUE  = 2'd1,
        CMD_PROCESS    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_WAKING   = 2'd0,
        MODE_RUNNING  = 2'd1,
        MODE_SLEEPING = 2'd2
    } t_mode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    localparam logic [7:0] FRAME_SWITCH = 8'd0;
    localparam logic [7:0] FRAME_VALUE  = 8'd1;

    localparam logic [1:0] CFG_ACCESSORY = 2'd0;
    localparam logic [1:0] CFG_IGNITION  = 2'd1;
    localparam logic [1:0] CFG_PARKLIGHT = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd3;

    localparam logic [3:0]  RST_ACCESSORY = 4'd0;
    localparam logic [3:0]  RST_IGNITION  = 4'd1;
    localparam logic [3:0]  RST_PARKLIGHT = 4'd2;
    localparam logic [15:0] RST_TIMEOUT   = 16'd5000;

    // One stacked transmit message.
    typedef struct packed {
        logic        typ;
        logic [3:0]  idx;
        logic [15:0] val;
    } t_msg;

    typedef struct packed {
        logic push;
        logic pop;
        t_msg msg;
    } t_stk_ctl;

    typedef struct packed {
        logic empty;
        logic one;
        logic full;
    } t_stk_stat;

endpackage

/* hdl/swvs_stack.sv */
// Last-in-first-out transmit message stack in a synchronous memory.
module swvs_stack #(
    parameter int STACK_DEPTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd,
    input  swvs_pkg::t_stk_ctl  i_ctl,
    output swvs_pkg::t_msg      o_top,
    output swvs_pkg::t_stk_stat o_stat
);
    import swvs_pkg::*;

    localparam int ST_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    t_msg             r_mem [STACK_DEPTH];
    t_msg             r_top;
    logic [CNT_W-1:0] r_count;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.one   = (r_count == CNT_W'(1));
    assign o_stat.full  = (r_count == CNT_W'(STACK_DEPTH));
    assign o_top        = r_top;

    // Read the top entry ahead of use; count holds until the item commits.
    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_top <= r_mem[ST_AW'(r_count - 1'b1)];
        end
        if (i_ctl.push && !o_stat.full) begin
            r_mem[ST_AW'(r_count)] <= i_ctl.msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.push && !o_stat.full) begin
            r_count <= r_count + 1'b1;
        end else if (i_ctl.pop && !o_stat.empty) begin
            r_count <= r_count - 1'b1;
        end
    end

endmodule

/* hdl/switch_value_shadow_with_tx_stack.sv */
// Top level: switch/value shadow table, transmit stack and power mode.
//
//  channel   direction  handshake                     payload
//  in        sink       i_in_valid / o_in_stall       i_command .. i_now_ms
//  out       source     o_out_valid / i_out_stall     o_tx_valid .. o_message_dropped
//  cfg       sink       i_cfg_we                      i_cfg_index, i_cfg_data
//
// Each word is handled in two steps: the accept cycle reads the value memory and the
// stack top; the execute state compares, writes back and loads the result register.
// A new word is taken only once the previous one has committed.
// A stalled result register holds the execute state until it frees.
// Synchronous reset clears the switch bits, value valid bits, stack count, mode, wake
// time, state and result valid, and loads configuration defaults; no clearing pass is needed.
module switch_value_shadow_with_tx_stack #(
    parameter int SWITCH_COUNT = 16,
    parameter int VALUE_COUNT  = 16,
    parameter int STACK_DEPTH  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_entry_index,
    input  logic [15:0] i_entry_value,
    input  logic        i_transmit,
    input  logic        i_frame_valid,
    input  logic [7:0]  i_frame_type,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_tx_valid,
    output logic        o_tx_type,
    output logic [3:0]  o_tx_index,
    output logic [15:0] o_tx_value,
    output logic [1:0]  o_power_mode,
    output logic        o_entry_changed,
    output logic        o_message_dropped,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import swvs_pkg::*;

    localparam int SW_AW = (SWITCH_COUNT > 1) ? $clog2(SWITCH_COUNT) : 1;
    localparam int VA_W  = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;

    // configuration
    logic [3:0]  r_acc_idx, r_ign_idx, r_park_idx;
    logic [15:0] r_timeout;

    // control state
    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic [31:0] r_wake;
    logic [SWITCH_COUNT-1:0] r_sw, n_sw;
    logic [VALUE_COUNT-1:0]  r_vok;
    logic [15:0] r_vmem [VALUE_COUNT];
    logic [15:0] r_vq;

    // latched word
    logic [1:0]  r_cmd;
    logic [3:0]  r_idx;
    logic [15:0] r_val;
    logic        r_tx, r_fv;
    logic [7:0]  r_ft;
    logic [31:0] r_now;

    // result register
    logic        r_out_valid;
    logic        r_tx_valid, r_tx_type, r_changed, r_dropped;
    logic [3:0]  r_tx_index;
    logic [15:0] r_tx_value;
    logic [1:0]  r_power_mode;

    logic        accept, commit, out_free;
    logic        is_set, is_proc, apply, typ, on, sw_in, v_in, sw_old;
    logic        sw_chg, v_chg, changed, push, dropped, pop, reason;
    logic [15:0] v_old;
    logic [31:0] n_wake, elapsed;
    t_mode       mode_m;
    t_msg        stk_top;
    t_stk_ctl    stk_ctl;
    t_stk_stat   stk_stat;

    function automatic logic sw_on(input logic [SWITCH_COUNT-1:0] tbl,
                                   input logic [3:0] k);
        logic hit;
        hit = 1'b0;
        if (32'(k) < SWITCH_COUNT) begin
            hit = tbl[SW_AW'(k)];
        end
        return hit;
    endfunction

    swvs_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rd   (accept),
        .i_ctl  (stk_ctl),
        .o_top  (stk_top),
        .o_stat (stk_stat)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        accept  = 1'b0;
        commit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    accept  = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    commit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Compare against the stored entry and work out the new state.
    always_comb begin
        is_set  = (r_cmd == CMD_SET_SWITCH) || (r_cmd == CMD_SET_VALUE);
        is_proc = (r_cmd == CMD_PROCESS);
        apply   = is_set || (is_proc && r_fv &&
                  (r_ft == FRAME_SWITCH || r_ft == FRAME_VALUE));
        typ     = is_set ? r_cmd[0] : r_ft[0];
        on      = (r_val != 16'd0);
        sw_in   = 32'(r_idx) < SWITCH_COUNT;
        v_in    = 32'(r_idx) < VALUE_COUNT;
        sw_old  = sw_on(r_sw, r_idx);
        v_old   = 16'd0;
        if (v_in && r_vok[VA_W'(r_idx)]) begin
            v_old = r_vq;
        end
        sw_chg  = apply && !typ && sw_in && (sw_old != on);
        v_chg   = apply && typ && v_in && (v_old != r_val);
        changed = sw_chg || v_chg;
        push    = changed && is_set && r_tx;
        dropped = push && stk_stat.full;
        pop     = is_proc && !stk_stat.empty;

        n_sw = r_sw;
        if (sw_chg) begin
            n_sw[SW_AW'(r_idx)] = on;
        end

        stk_ctl.push    = commit && push;
        stk_ctl.pop     = commit && pop;
        stk_ctl.msg.typ = typ;
        stk_ctl.msg.idx = r_idx;
        stk_ctl.msg.val = typ ? r_val : {15'd0, on};

        // A process word arriving in sleep is the wake-up.
        mode_m  = (r_mode == MODE_SLEEPING) ? MODE_WAKING : r_mode;
        n_wake  = (r_mode == MODE_SLEEPING) ? r_now : r_wake;
        elapsed = r_now - n_wake;
        reason  = sw_on(n_sw, r_acc_idx) || sw_on(n_sw, r_ign_idx) ||
                  sw_on(n_sw, r_park_idx) || (!stk_stat.empty && !stk_stat.one);
        n_mode  = r_mode;
        if (is_proc) begin
            if (reason) begin
                n_mode = MODE_RUNNING;
            end else if (mode_m == MODE_WAKING && elapsed <= {16'd0, r_timeout}) begin
                n_mode = MODE_WAKING;
            end else begin
                n_mode = MODE_SLEEPING;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mode     <= MODE_WAKING;
            r_wake     <= 32'd0;
            r_sw       <= '0;
            r_vok      <= '0;
            r_acc_idx  <= RST_ACCESSORY;
            r_ign_idx  <= RST_IGNITION;
            r_park_idx <= RST_PARKLIGHT;
            r_timeout  <= RST_TIMEOUT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACCESSORY: r_acc_idx  <= i_cfg_data[3:0];
                    CFG_IGNITION:  r_ign_idx  <= i_cfg_data[3:0];
                    CFG_PARKLIGHT: r_park_idx <= i_cfg_data[3:0];
                    CFG_TIMEOUT:   r_timeout  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (commit) begin
                r_mode <= n_mode;
                r_sw   <= n_sw;
                if (is_proc) begin
                    r_wake <= n_wake;
                end
                if (v_chg) begin
                    r_vok[VA_W'(r_idx)] <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Value memory: read on accept, write back on commit.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vq <= r_vmem[VA_W'(i_entry_index)];
        end
        if (commit && v_chg) begin
            r_vmem[VA_W'(r_idx)] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_idx <= i_entry_index;
            r_val <= i_entry_value;
            r_tx  <= i_transmit;
            r_fv  <= i_frame_valid;
            r_ft  <= i_frame_type;
            r_now <= i_now_ms;
        end
        if (commit) begin
            r_tx_valid   <= pop;
            r_tx_type    <= pop ? stk_top.typ : 1'b0;
            r_tx_index   <= pop ? stk_top.idx : 4'd0;
            r_tx_value   <= pop ? stk_top.val : 16'd0;
            r_power_mode <= n_mode;
            r_changed    <= changed;
            r_dropped    <= dropped;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_tx_valid        = r_tx_valid;
    assign o_tx_type         = r_tx_type;
    assign o_tx_index        = r_tx_index;
    assign o_tx_value        = r_tx_value;
    assign o_power_mode      = r_power_mode;
    assign o_entry_changed   = r_changed;
    assign o_message_dropped = r_dropped;

    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && dropped) |-> stk_stat.full)
        else $error("message dropped while stack had room");

    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_EXEC))
        else $error("result appeared without an execute cycle");

    a_pop_never_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tx_valid) |-> !o_message_dropped)
        else $error("pop and drop reported on one word");

endmodule
